// ----- src/tdrt_pkg.sv -----
// Shared types and constants of the transmit descriptor ring tracker.
package tdrt_pkg;

    // Descriptor status words carried by every item, and their index width
    localparam int unsigned DESC_WORDS = 4;
    localparam int unsigned SLOT_W     = 2;

    // Transmit status bits
    localparam logic [31:0] ST_CARRIER  = 32'h8000_0000;
    localparam logic [31:0] ST_ABORTED  = 32'h4000_0000;
    localparam logic [31:0] ST_OWC      = 32'h2000_0000;
    localparam logic [31:0] ST_OK       = 32'h0000_8000;
    localparam logic [31:0] ST_UNDERRUN = 32'h0000_4000;
    localparam logic [31:0] ST_DONE     = ST_CARRIER | ST_ABORTED | ST_OWC | ST_OK | ST_UNDERRUN;

    // Early transmit threshold field written with every send
    localparam logic [31:0] TX_FLAGS    = (32'd256 << 11) & 32'h003F_0000;

    // Receive overflow bits of the interrupt status
    localparam logic [15:0] IRQ_OVERFLOW = 16'h0010 | 16'h0040;

    // Short frames are padded to this length
    localparam logic [10:0] MIN_FRAME_LEN = 11'd60;

    // Item kinds
    localparam logic MODE_POLL = 1'b0;
    localparam logic MODE_SEND = 1'b1;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_RETIRE,
        ST_ISSUE,
        ST_FINISH
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic start;
        logic retire_one;
        logic issue;
        logic drop;
        logic publish;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic go;
        logic is_send;
        logic retire_ok;
        logic ring_full;
        logic out_busy;
    } stat_t;

endpackage

// ----- src/tdrt_ctrl.sv -----
// Sequencing controller of the transmit descriptor ring tracker.
module tdrt_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  tdrt_pkg::stat_t stat,
    output tdrt_pkg::cmd_t  cmd,
    output logic           in_stall
);

    tdrt_pkg::state_t state_reg;
    tdrt_pkg::state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tdrt_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            tdrt_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = tdrt_pkg::ST_EVAL;
                end
            end
            tdrt_pkg::ST_EVAL:
            begin
                cmd.start  = 1'b1;
                state_next = stat.go ? tdrt_pkg::ST_RETIRE : tdrt_pkg::ST_FINISH;
            end
            tdrt_pkg::ST_RETIRE:
            begin
                // one descriptor per cycle until the first unfinished one or an empty ring
                if (stat.retire_ok)
                begin
                    cmd.retire_one = 1'b1;
                end
                else if (stat.is_send)
                begin
                    state_next = tdrt_pkg::ST_ISSUE;
                end
                else
                begin
                    state_next = tdrt_pkg::ST_FINISH;
                end
            end
            tdrt_pkg::ST_ISSUE:
            begin
                if (stat.ring_full)
                begin
                    cmd.drop = 1'b1;
                end
                else
                begin
                    cmd.issue = 1'b1;
                end
                state_next = tdrt_pkg::ST_FINISH;
            end
            tdrt_pkg::ST_FINISH:
            begin
                if (!stat.out_busy)
                begin
                    cmd.publish = 1'b1;
                    state_next  = tdrt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tdrt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- src/tdrt_datapath.sv -----
// Ring pointers, counters, item registers and result register of the tracker.
module tdrt_datapath
#(
    parameter int unsigned DESCRIPTORS   = 4,
    parameter int unsigned MAX_FRAME_LEN = 1792
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  tdrt_pkg::cmd_t  cmd,
    output tdrt_pkg::stat_t stat,
    // configuration
    input  logic            cfg_we,
    input  logic            cfg_enabled,
    // item fields
    input  logic            mode,
    input  logic [10:0]     frame_bytes,
    input  logic            link_up,
    input  logic [15:0]     irq_status,
    input  logic [31:0]     desc_status0,
    input  logic [31:0]     desc_status1,
    input  logic [31:0]     desc_status2,
    input  logic [31:0]     desc_status3,
    // result
    input  logic            out_stall,
    output logic            out_valid,
    output logic            accepted,
    output logic [1:0]      entry,
    output logic [31:0]     status_write,
    output logic [2:0]      retired,
    output logic [2:0]      in_flight,
    output logic [31:0]     sent_count,
    output logic [31:0]     send_error_count,
    output logic [31:0]     send_drop_count,
    output logic [31:0]     overflow_count
);

    localparam int unsigned PTR_MOD = 2 * DESCRIPTORS;
    localparam int unsigned PTR_W   = $clog2(PTR_MOD);
    localparam int unsigned OUT_W   = PTR_W + 1;

    // Item registers
    logic                        mode_reg;
    logic [10:0]                 len_reg;
    logic                        link_reg;
    logic [15:0]                 irq_reg;
    logic [31:0]                 desc_reg [tdrt_pkg::DESC_WORDS];

    // Control state
    logic                        enabled_reg,   enabled_next;
    logic [PTR_W-1:0]            issue_reg,     issue_next;
    logic [PTR_W-1:0]            retire_reg,    retire_next;
    logic [31:0]                 sent_reg,      sent_next;
    logic [31:0]                 err_reg,       err_next;
    logic [31:0]                 drop_reg,      drop_next;
    logic [31:0]                 ovf_reg,       ovf_next;
    logic                        work_acc_reg,  work_acc_next;
    logic [1:0]                  work_entry_reg, work_entry_next;
    logic [31:0]                 work_stat_reg, work_stat_next;
    logic [2:0]                  work_ret_reg,  work_ret_next;
    logic                        out_valid_reg, out_valid_next;

    // Result register
    logic                        out_acc_reg;
    logic [1:0]                  out_entry_reg;
    logic [31:0]                 out_stat_reg;
    logic [2:0]                  out_ret_reg;
    logic [2:0]                  out_flight_reg;
    logic [31:0]                 out_sent_reg;
    logic [31:0]                 out_err_reg;
    logic [31:0]                 out_drop_reg;
    logic [31:0]                 out_ovf_reg;

    logic [OUT_W-1:0]            diff;
    logic [OUT_W-1:0]            outstanding;
    logic [PTR_W-1:0]            retire_mod;
    logic [PTR_W-1:0]            issue_mod;
    logic [tdrt_pkg::SLOT_W-1:0] retire_slot;
    logic [tdrt_pkg::SLOT_W-1:0] issue_slot;
    logic [31:0]                 cur_st;
    logic                        st_hard_err;
    logic                        send_ok;
    logic [10:0]                 padded_len;

    // Occupancy: pointers count modulo twice the ring size
    always_comb
    begin
        diff = {1'b0, issue_reg} + OUT_W'(PTR_MOD) - {1'b0, retire_reg};
        if (diff >= OUT_W'(PTR_MOD))
        begin
            outstanding = diff - OUT_W'(PTR_MOD);
        end
        else
        begin
            outstanding = diff;
        end
    end

    // Pointer to descriptor slot, pointer < 2 * DESCRIPTORS
    always_comb
    begin
        retire_mod = (retire_reg >= PTR_W'(DESCRIPTORS)) ?
                     retire_reg - PTR_W'(DESCRIPTORS) : retire_reg;
        issue_mod  = (issue_reg >= PTR_W'(DESCRIPTORS)) ?
                     issue_reg - PTR_W'(DESCRIPTORS) : issue_reg;
    end

    assign retire_slot = tdrt_pkg::SLOT_W'(retire_mod);
    assign issue_slot  = tdrt_pkg::SLOT_W'(issue_mod);
    assign cur_st      = desc_reg[retire_slot];
    assign st_hard_err = |(cur_st & (tdrt_pkg::ST_ABORTED | tdrt_pkg::ST_OWC));

    // Send checks and padding
    assign send_ok    = (len_reg != 11'd0) && (len_reg <= 11'(MAX_FRAME_LEN)) && link_reg;
    assign padded_len = (len_reg < tdrt_pkg::MIN_FRAME_LEN) ? tdrt_pkg::MIN_FRAME_LEN : len_reg;

    // Status to the controller
    always_comb
    begin
        stat.go        = enabled_reg && ((mode_reg == tdrt_pkg::MODE_POLL) || send_ok);
        stat.is_send   = (mode_reg == tdrt_pkg::MODE_SEND);
        stat.retire_ok = (outstanding != '0) && (|(cur_st & tdrt_pkg::ST_DONE));
        stat.ring_full = (outstanding >= OUT_W'(DESCRIPTORS));
        stat.out_busy  = out_valid_reg && out_stall;
    end

    // Next values of the control state
    always_comb
    begin
        enabled_next    = enabled_reg;
        issue_next      = issue_reg;
        retire_next     = retire_reg;
        sent_next       = sent_reg;
        err_next        = err_reg;
        drop_next       = drop_reg;
        ovf_next        = ovf_reg;
        work_acc_next   = work_acc_reg;
        work_entry_next = work_entry_reg;
        work_stat_next  = work_stat_reg;
        work_ret_next   = work_ret_reg;
        out_valid_next  = out_valid_reg;

        if (cfg_we)
        begin
            enabled_next = cfg_enabled;
        end

        // new step: clear per-item results, count overflow on a retiring step
        if (cmd.start)
        begin
            work_acc_next   = 1'b0;
            work_entry_next = '0;
            work_stat_next  = '0;
            work_ret_next   = '0;
            if (stat.go && (|(irq_reg & tdrt_pkg::IRQ_OVERFLOW)))
            begin
                ovf_next = ovf_reg + 32'd1;
            end
        end

        // retire the descriptor under the retire pointer
        if (cmd.retire_one)
        begin
            retire_next   = (retire_reg == PTR_W'(PTR_MOD - 1)) ? '0 : retire_reg + PTR_W'(1);
            work_ret_next = work_ret_reg + 3'd1;
            if (st_hard_err)
            begin
                err_next = err_reg + 32'd1;
            end
            else
            begin
                sent_next = sent_reg + 32'd1;
                if (|(cur_st & tdrt_pkg::ST_UNDERRUN))
                begin
                    err_next = err_reg + 32'd1;
                end
            end
        end

        // place the send in the next free descriptor
        if (cmd.issue)
        begin
            issue_next      = (issue_reg == PTR_W'(PTR_MOD - 1)) ? '0 : issue_reg + PTR_W'(1);
            work_acc_next   = 1'b1;
            work_entry_next = issue_slot;
            work_stat_next  = tdrt_pkg::TX_FLAGS | {21'd0, padded_len};
        end

        if (cmd.drop)
        begin
            drop_next = drop_reg + 32'd1;
        end

        // result register handshake
        if (cmd.publish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg    <= 1'b0;
            issue_reg      <= '0;
            retire_reg     <= '0;
            sent_reg       <= '0;
            err_reg        <= '0;
            drop_reg       <= '0;
            ovf_reg        <= '0;
            work_acc_reg   <= 1'b0;
            work_entry_reg <= '0;
            work_stat_reg  <= '0;
            work_ret_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            enabled_reg    <= enabled_next;
            issue_reg      <= issue_next;
            retire_reg     <= retire_next;
            sent_reg       <= sent_next;
            err_reg        <= err_next;
            drop_reg       <= drop_next;
            ovf_reg        <= ovf_next;
            work_acc_reg   <= work_acc_next;
            work_entry_reg <= work_entry_next;
            work_stat_reg  <= work_stat_next;
            work_ret_reg   <= work_ret_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Item capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg    <= mode;
            len_reg     <= frame_bytes;
            link_reg    <= link_up;
            irq_reg     <= irq_status;
            desc_reg[0] <= desc_status0;
            desc_reg[1] <= desc_status1;
            desc_reg[2] <= desc_status2;
            desc_reg[3] <= desc_status3;
        end
    end

    // Result capture
    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            out_acc_reg    <= work_acc_reg;
            out_entry_reg  <= work_entry_reg;
            out_stat_reg   <= work_stat_reg;
            out_ret_reg    <= work_ret_reg;
            out_flight_reg <= 3'(outstanding);
            out_sent_reg   <= sent_reg;
            out_err_reg    <= err_reg;
            out_drop_reg   <= drop_reg;
            out_ovf_reg    <= ovf_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign accepted         = out_acc_reg;
    assign entry            = out_entry_reg;
    assign status_write     = out_stat_reg;
    assign retired          = out_ret_reg;
    assign in_flight        = out_flight_reg;
    assign sent_count       = out_sent_reg;
    assign send_error_count = out_err_reg;
    assign send_drop_count  = out_drop_reg;
    assign overflow_count   = out_ovf_reg;

    // Ring never holds more than its size
    a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        outstanding <= OUT_W'(DESCRIPTORS))
        else $error("ring occupancy beyond ring size");

    // A result is never written over one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |-> !(out_valid_reg && out_stall))
        else $error("result register overwritten while stalled");

    // Retire only a finished, outstanding descriptor
    a_retire_ok: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.retire_one |-> stat.retire_ok)
        else $error("retired an unfinished descriptor");

    // Issue only into a ring with room
    a_issue_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> !stat.ring_full)
        else $error("send issued into a full ring");

endmodule

// ----- src/tx_descriptor_ring_tracker.sv -----
// Top level of the transmit descriptor ring tracker.
//
// Input channel (in_valid / in_stall) carries one item: a poll or a send
// request with the four descriptor status words and the interrupt status.
// An item is taken when in_valid is high and in_stall low. Output channel
// (out_valid / out_stall) returns exactly one result item per input item.
// Configuration channel (cfg_valid / cfg_ready, data on enabled) writes the
// enable bit; cfg_ready is always high.
//
// A send passes from evaluation to the retire state, where k descriptors
// (0 to DESCRIPTORS) are retired one at a time until the first unfinished
// one or an empty ring, then to issuing or dropping the send and then to
// publication. A poll skips the issue step; refused and disabled items go
// from evaluation straight to publication. The next item is accepted the
// cycle after publication, so a result left waiting in the result register
// does not block it; only a second result waits for the first to be taken.
//
// Reset clears the enable bit, the ring pointers and all counters. While
// out_valid and out_stall are high the result register holds its contents.
module tx_descriptor_ring_tracker
#(
    parameter int unsigned DESCRIPTORS   = 4,
    parameter int unsigned MAX_FRAME_LEN = 1792
)
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        enabled,
    // input items
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        mode,
    input  logic [10:0] frame_bytes,
    input  logic        link_up,
    input  logic [15:0] irq_status,
    input  logic [31:0] desc_status0,
    input  logic [31:0] desc_status1,
    input  logic [31:0] desc_status2,
    input  logic [31:0] desc_status3,
    // result items
    output logic        out_valid,
    input  logic        out_stall,
    output logic        accepted,
    output logic [1:0]  entry,
    output logic [31:0] status_write,
    output logic [2:0]  retired,
    output logic [2:0]  in_flight,
    output logic [31:0] sent_count,
    output logic [31:0] send_error_count,
    output logic [31:0] send_drop_count,
    output logic [31:0] overflow_count
);

    tdrt_pkg::cmd_t  cmd;
    tdrt_pkg::stat_t stat;

    // Register writes are always taken
    assign cfg_ready = 1'b1;

    // Controller
    tdrt_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .stat     (stat),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    // Datapath
    tdrt_datapath
    #(
        .DESCRIPTORS   (DESCRIPTORS),
        .MAX_FRAME_LEN (MAX_FRAME_LEN)
    )
    u_datapath
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .cfg_we           (cfg_valid && cfg_ready),
        .cfg_enabled      (enabled),
        .mode             (mode),
        .frame_bytes      (frame_bytes),
        .link_up          (link_up),
        .irq_status       (irq_status),
        .desc_status0     (desc_status0),
        .desc_status1     (desc_status1),
        .desc_status2     (desc_status2),
        .desc_status3     (desc_status3),
        .out_stall        (out_stall),
        .out_valid        (out_valid),
        .accepted         (accepted),
        .entry            (entry),
        .status_write     (status_write),
        .retired          (retired),
        .in_flight        (in_flight),
        .sent_count       (sent_count),
        .send_error_count (send_error_count),
        .send_drop_count  (send_drop_count),
        .overflow_count   (overflow_count)
    );

endmodule

// ----- test/tb_tx_descriptor_ring_tracker.sv -----
// Self-checking testbench for the transmit descriptor ring tracker.
package ring_check_pkg;

    localparam int unsigned RING_SLOTS = 4;
    localparam int unsigned MAX_LEN    = 1792;

    // One poll or send request as presented on the input channel
    typedef struct packed {
        logic             mode;
        logic [10:0]      frame_bytes;
        logic             link_up;
        logic [15:0]      irq_status;
        logic [3:0][31:0] desc;
    } request_t;

    // One step report as seen on the output channel
    typedef struct packed {
        logic        accepted;
        logic [1:0]  entry;
        logic [31:0] status_write;
        logic [2:0]  retired;
        logic [2:0]  in_flight;
        logic [31:0] sent_count;
        logic [31:0] send_error_count;
        logic [31:0] send_drop_count;
        logic [31:0] overflow_count;
    } report_t;

    // Ring state mirror plus the queue of step reports still due from the block
    class ring_ledger;
        bit          enabled;
        bit [2:0]    issue_ptr;
        bit [2:0]    retire_ptr;
        bit [31:0]   packets_sent;
        bit [31:0]   send_errors;
        bit [31:0]   send_drops;
        bit [31:0]   overflow_errors;
        report_t     due_reports[$];
        int          mismatches;
        int          requests_seen;
        int          reports_checked;
        int          sends_placed;
        int          total_retired;

        function new();
            enabled         = 1'b0;
            issue_ptr       = '0;
            retire_ptr      = '0;
            packets_sent    = '0;
            send_errors     = '0;
            send_drops      = '0;
            overflow_errors = '0;
            mismatches      = 0;
            requests_seen   = 0;
            reports_checked = 0;
            sends_placed    = 0;
            total_retired   = 0;
        endfunction

        function void set_enabled(bit v);
            enabled = v;
        endfunction

        function int pending();
            return due_reports.size();
        endfunction

        // pointers run modulo 8, so the 3-bit difference is the ring fill
        function bit [2:0] ring_used();
            return issue_ptr - retire_ptr;
        endfunction

        // count overflow; retire done descriptors in order to the first not done
        function bit [2:0] retire_finished(request_t rq);
            bit [2:0]  n;
            bit [31:0] st;
            n = '0;
            if ((rq.irq_status & tdrt_pkg::IRQ_OVERFLOW) != 0)
                overflow_errors++;
            while (ring_used() != 0) begin
                st = rq.desc[retire_ptr[1:0]];
                if ((st & tdrt_pkg::ST_DONE) == 0)
                    break;
                if ((st & (tdrt_pkg::ST_ABORTED | tdrt_pkg::ST_OWC)) != 0) begin
                    send_errors++;
                end
                else begin
                    if ((st & tdrt_pkg::ST_UNDERRUN) != 0)
                        send_errors++;
                    packets_sent++;
                end
                retire_ptr++;
                n++;
            end
            return n;
        endfunction

        // predict the report for one accepted request
        function void take_request(request_t rq);
            report_t     r;
            logic [10:0] plen;
            r = '0;
            requests_seen++;
            if (enabled) begin
                if (rq.mode == tdrt_pkg::MODE_POLL) begin
                    r.retired = retire_finished(rq);
                end
                else if (rq.frame_bytes != 0 && rq.frame_bytes <= MAX_LEN
                         && rq.link_up) begin
                    r.retired = retire_finished(rq);
                    if (ring_used() >= RING_SLOTS) begin
                        send_drops++;
                    end
                    else begin
                        plen = (rq.frame_bytes < tdrt_pkg::MIN_FRAME_LEN) ?
                               tdrt_pkg::MIN_FRAME_LEN : rq.frame_bytes;
                        r.entry        = issue_ptr[1:0];
                        r.status_write = tdrt_pkg::TX_FLAGS | {21'd0, plen};
                        r.accepted     = 1'b1;
                        issue_ptr++;
                        sends_placed++;
                    end
                end
            end
            total_retired     += r.retired;
            r.in_flight        = ring_used();
            r.sent_count       = packets_sent;
            r.send_error_count = send_errors;
            r.send_drop_count  = send_drops;
            r.overflow_count   = overflow_errors;
            due_reports.push_back(r);
        endfunction

        task report(string msg);
            $display("MISMATCH report %0d: %s", reports_checked, msg);
            mismatches++;
        endtask

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
        endtask

        // compare one report from the block with the oldest prediction
        task check_report(report_t got);
            report_t want;
            if (due_reports.size() == 0) begin
                report("report arrived with no request outstanding");
            end
            else begin
                want = due_reports.pop_front();
                compare_field("accepted", got.accepted, want.accepted);
                compare_field("entry", got.entry, want.entry);
                compare_field("status_write", got.status_write, want.status_write);
                compare_field("retired", got.retired, want.retired);
                compare_field("in_flight", got.in_flight, want.in_flight);
                compare_field("sent_count", got.sent_count, want.sent_count);
                compare_field("send_error_count", got.send_error_count,
                              want.send_error_count);
                compare_field("send_drop_count", got.send_drop_count,
                              want.send_drop_count);
                compare_field("overflow_count", got.overflow_count, want.overflow_count);
            end
            reports_checked++;
        endtask
    endclass

endpackage

module tb_tx_descriptor_ring_tracker;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DRAIN_CYCLES = 12;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic                       enabled;
    logic                       in_valid;
    logic                       in_stall;
    logic                       out_valid;
    logic                       out_stall;
    ring_check_pkg::request_t   cur;
    ring_check_pkg::report_t    seen;
    bit                         quiet;
    ring_check_pkg::ring_ledger ledger;

    tx_descriptor_ring_tracker
    #(
        .DESCRIPTORS   (ring_check_pkg::RING_SLOTS),
        .MAX_FRAME_LEN (ring_check_pkg::MAX_LEN)
    )
    dut
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .enabled          (enabled),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .mode             (cur.mode),
        .frame_bytes      (cur.frame_bytes),
        .link_up          (cur.link_up),
        .irq_status       (cur.irq_status),
        .desc_status0     (cur.desc[0]),
        .desc_status1     (cur.desc[1]),
        .desc_status2     (cur.desc[2]),
        .desc_status3     (cur.desc[3]),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .accepted         (seen.accepted),
        .entry            (seen.entry),
        .status_write     (seen.status_write),
        .retired          (seen.retired),
        .in_flight        (seen.in_flight),
        .sent_count       (seen.sent_count),
        .send_error_count (seen.send_error_count),
        .send_drop_count  (seen.send_drop_count),
        .overflow_count   (seen.overflow_count)
    );

    // 12 ns clock
    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // hard limit on run length
    initial
    begin
        #5_000_000;
        $display("timeout with %0d reports still due", ledger.pending());
        $display("tb_tx_descriptor_ring_tracker NOT OK");
        $finish;
    end

    // receiver stall, about 35 percent of cycles unless in a quiet stretch
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            out_stall = rst_n && !quiet && ($urandom_range(0, 99) < 35);
        end
    end

    // check every report taken from the block
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            ledger.check_report(seen);
    end

    function automatic ring_check_pkg::request_t make_request(logic m, logic [10:0] len,
                                                              logic link,
                                                              logic [15:0] irq,
                                                              logic [31:0] d0,
                                                              logic [31:0] d1,
                                                              logic [31:0] d2,
                                                              logic [31:0] d3);
        ring_check_pkg::request_t rq;
        rq.mode        = m;
        rq.frame_bytes = len;
        rq.link_up     = link;
        rq.irq_status  = irq;
        rq.desc[0]     = d0;
        rq.desc[1]     = d1;
        rq.desc[2]     = d2;
        rq.desc[3]     = d3;
        return rq;
    endfunction

    // descriptor status word: done with some completion mix, or still pending
    function automatic logic [31:0] random_status(int done_pct);
        logic [31:0] w;
        w = $urandom;
        if ($urandom_range(0, 99) < done_pct) begin
            case ($urandom_range(0, 7))
                0: w = (w & ~tdrt_pkg::ST_DONE) | tdrt_pkg::ST_OK;
                1: w = (w & ~tdrt_pkg::ST_DONE) | tdrt_pkg::ST_OK | tdrt_pkg::ST_UNDERRUN;
                2: w = (w & ~tdrt_pkg::ST_DONE) | tdrt_pkg::ST_UNDERRUN;
                3: w = (w & ~tdrt_pkg::ST_DONE) | tdrt_pkg::ST_ABORTED |
                       ($urandom_range(0, 1) ? tdrt_pkg::ST_OK : '0);
                4: w = (w & ~tdrt_pkg::ST_DONE) | tdrt_pkg::ST_OWC;
                5: w = (w & ~tdrt_pkg::ST_DONE) | tdrt_pkg::ST_CARRIER;
                6: w = (w & ~tdrt_pkg::ST_DONE) | tdrt_pkg::ST_CARRIER | tdrt_pkg::ST_OK;
                default: ;
            endcase
        end
        else begin
            w = w & ~tdrt_pkg::ST_DONE;
        end
        return w;
    endfunction

    // mostly well-formed polls and sends, some refused sends as noise
    function automatic ring_check_pkg::request_t random_request(int done_pct);
        ring_check_pkg::request_t rq;
        rq.mode = ($urandom_range(0, 99) < 55) ? tdrt_pkg::MODE_SEND : tdrt_pkg::MODE_POLL;
        case ($urandom_range(0, 19)) inside
            0:       rq.frame_bytes = '0;
            1:       rq.frame_bytes = 11'($urandom_range(ring_check_pkg::MAX_LEN + 1, 2047));
            [2:3]:   rq.frame_bytes = 11'($urandom_range(1, 59));
            4:       rq.frame_bytes = $urandom_range(0, 1) ? 11'd60 :
                                      11'(ring_check_pkg::MAX_LEN);
            default: rq.frame_bytes = 11'($urandom_range(1, ring_check_pkg::MAX_LEN));
        endcase
        rq.link_up    = ($urandom_range(0, 99) < 93);
        rq.irq_status = 16'($urandom);
        if ($urandom_range(0, 99) < 70)
            rq.irq_status = rq.irq_status & ~tdrt_pkg::IRQ_OVERFLOW;
        for (int i = 0; i < 4; i++)
            rq.desc[i] = random_status(done_pct);
        return rq;
    endfunction

    // present one request, idling at random first, and wait for it to be taken
    task automatic push_request(ring_check_pkg::request_t rq);
        if (!quiet) begin
            while ($urandom_range(0, 99) < 35) begin
                in_valid = 1'b0;
                @(negedge clk);
            end
        end
        in_valid = 1'b1;
        cur      = rq;
        do
            @(posedge clk);
        while (in_stall);
        ledger.take_request(rq);
        @(negedge clk);
    endtask

    // write the enable bit once every report is back and the block is idle
    task automatic write_enable(logic v);
        in_valid = 1'b0;
        while (ledger.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b1;
        enabled   = v;
        do
            @(posedge clk);
        while (!cfg_ready);
        ledger.set_enabled(v);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // one random phase under a given enable setting
    task automatic run_phase(logic en, int count, int quiet_from, int quiet_to);
        int done_pct;
        write_enable(en);
        done_pct = 50;
        for (int i = 0; i < count; i++) begin
            if (i % 40 == 0)
                done_pct = ($urandom_range(0, 2) == 0) ? 10 :
                           ($urandom_range(0, 1) ? 50 : 90);
            quiet = (i >= quiet_from && i < quiet_to);
            push_request(random_request(done_pct));
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        ledger    = new();
        quiet     = 1'b0;
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        enabled   = 1'b0;
        in_valid  = 1'b0;
        cur       = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // disabled after reset: both kinds are ignored
        push_request(make_request(tdrt_pkg::MODE_POLL, 11'd0, 1'b1, 16'hFFFF,
                                  '1, '1, '1, '1));
        push_request(make_request(tdrt_pkg::MODE_SEND, 11'd100, 1'b1, 16'h0050,
                                  '1, '1, '1, '1));
        write_enable(1'b1);

        // refused sends: zero length, too long, longest field value, link down
        push_request(make_request(tdrt_pkg::MODE_SEND, 11'd0, 1'b1, 16'h0000,
                                  tdrt_pkg::ST_OK, 0, 0, 0));
        push_request(make_request(tdrt_pkg::MODE_SEND, 11'(ring_check_pkg::MAX_LEN + 1),
                                  1'b1, 16'h0010, 0, 0, 0, 0));
        push_request(make_request(tdrt_pkg::MODE_SEND, 11'd2047, 1'b1, 16'h0000,
                                  0, 0, 0, 0));
        push_request(make_request(tdrt_pkg::MODE_SEND, 11'd100, 1'b0, 16'h0040,
                                  0, 0, 0, 0));

        // fill the ring: padding below 60, exactly 60, longest allowed
        push_request(make_request(tdrt_pkg::MODE_SEND, 11'd1, 1'b1, 16'h0000, 0, 0, 0, 0));
        push_request(make_request(tdrt_pkg::MODE_SEND, 11'd59, 1'b1, 16'h0000, 0, 0, 0, 0));
        push_request(make_request(tdrt_pkg::MODE_SEND, 11'd60, 1'b1, 16'h0000, 0, 0, 0, 0));
        push_request(make_request(tdrt_pkg::MODE_SEND, 11'(ring_check_pkg::MAX_LEN),
                                  1'b1, 16'h0000, 0, 0, 0, 0));

        // ring full drop, then a send that frees a slot by retiring first
        push_request(make_request(tdrt_pkg::MODE_SEND, 11'd100, 1'b1, 16'h0000,
                                  0, 0, 0, 0));
        push_request(make_request(tdrt_pkg::MODE_SEND, 11'd500, 1'b1, 16'h0000,
                                  tdrt_pkg::ST_OK, 0, 0, 0));

        // carrier lost alone, aborted, underrun; stop at the pending slot 0
        push_request(make_request(tdrt_pkg::MODE_POLL, 11'd0, 1'b1, 16'h0010, 32'h0,
                                  tdrt_pkg::ST_CARRIER, tdrt_pkg::ST_ABORTED,
                                  tdrt_pkg::ST_OK | tdrt_pkg::ST_UNDERRUN));
        // out of window in slot 0
        push_request(make_request(tdrt_pkg::MODE_POLL, 11'd0, 1'b1, 16'h0040,
                                  tdrt_pkg::ST_OWC, 0, 0, 0));
        // empty ring with every bit set
        push_request(make_request(tdrt_pkg::MODE_POLL, 11'd2047, 1'b0, 16'hFFFF,
                                  '1, '1, '1, '1));

        // fill again, then retire all four in one step across the pointer wrap
        push_request(make_request(tdrt_pkg::MODE_SEND, 11'd2, 1'b1, 16'h0000, 0, 0, 0, 0));
        push_request(make_request(tdrt_pkg::MODE_SEND, 11'd1000, 1'b1, 16'h0000,
                                  0, 0, 0, 0));
        push_request(make_request(tdrt_pkg::MODE_SEND, 11'd1791, 1'b1, 16'h0000,
                                  0, 0, 0, 0));
        push_request(make_request(tdrt_pkg::MODE_SEND, 11'd61, 1'b1, 16'h0000, 0, 0, 0, 0));
        push_request(make_request(tdrt_pkg::MODE_POLL, 11'd0, 1'b1, 16'h0000,
                                  tdrt_pkg::ST_OK, tdrt_pkg::ST_OK,
                                  tdrt_pkg::ST_OK, tdrt_pkg::ST_OK));

        // random phases across enable settings, one with a quiet stretch
        run_phase(1'b1, 500, -1, -1);
        run_phase(1'b0, 40, -1, -1);
        run_phase(1'b1, 720, 200, 460);
        run_phase(1'b0, 30, -1, -1);
        run_phase(1'b1, 680, -1, -1);

        // drain
        in_valid = 1'b0;
        while (ledger.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d requests, %0d reports checked: %0d sends placed, %0d dropped",
                 ledger.requests_seen, ledger.reports_checked, ledger.sends_placed,
                 ledger.send_drops);
        $display("%0d descriptors retired, %0d errors, %0d overflow steps, %0d mismatches",
                 ledger.total_retired, ledger.send_errors, ledger.overflow_errors,
                 ledger.mismatches);
        if (ledger.mismatches == 0)
            $display("tb_tx_descriptor_ring_tracker OK");
        else
            $display("tb_tx_descriptor_ring_tracker NOT OK");
        $finish;
    end

endmodule

// ----- files.f -----
src/tdrt_pkg.sv
src/tdrt_ctrl.sv
src/tdrt_datapath.sv
src/tx_descriptor_ring_tracker.sv
test/tb_tx_descriptor_ring_tracker.sv
